FILE: rtl/core/rlss_pkg.sv
// ----------------------------------------------------------------------------
// rlss_pkg
// Types, codes and character helpers for the range list to sorted set core.
// ----------------------------------------------------------------------------
package rlss_pkg;

	localparam int FIELD_W = 17;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SCAN
	} rlss_state_t;

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_LOW,
		PH_LEAD_DASH,
		PH_TRAIL_SEEK,
		PH_UPPER,
		PH_DONE_SINGLE,
		PH_DONE_RANGE
	} parse_phase_t;

	localparam logic OP_CHAR     = 1'b0;
	localparam logic OP_READ     = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_NONE = 1'b1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	function automatic logic is_delim(input logic [7:0] c);
		return c == CH_NUL || c == CH_SPACE || c == CH_COMMA || c == CH_SEMI ||
			c == CH_DOT || c == CH_AMP || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

endpackage

FILE: rtl/core/rlss_bitmap.sv
// ----------------------------------------------------------------------------
// rlss_bitmap
// One-bit-wide presence memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rlss_bitmap #(
	parameter int DEPTH = 65537,
	parameter int AW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [0:DEPTH-1];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/range_list_to_sorted_set_core.sv
// ----------------------------------------------------------------------------
// range_list_to_sorted_set_core
// Parses a text of integer ranges into a sorted set held in a presence bitmap
// and returns the members in increasing order on read-next requests.
// ----------------------------------------------------------------------------
// Operation: a finished token fills its range at one bitmap entry per cycle
// through a read-then-write pipeline; a read-next scans one entry per cycle
// from the cursor and returns the first member or, past the top, list end.
// Throughput: one beat per cycle while characters only accumulate and no
// result waits on a stalled output.
// Reset: a clearing pass sweeps the bitmap; the same pass runs when a new
// text starts. No beat is taken during the pass.
module range_list_to_sorted_set_core
	import rlss_pkg::*;
#(
	parameter int VALUE_MAX = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic               status,
	output logic [FIELD_W-1:0] value_count,
	output logic [FIELD_W-1:0] read_value,
	output logic               list_end
);

	// Address width of the bitmap, count/cursor width (up to VALUE_MAX+1),
	// and parsed-number width (up to VALUE_MAX+1, or a lone digit).
	localparam int AW = $clog2(VALUE_MAX + 1);
	localparam int CW = $clog2(VALUE_MAX + 2);
	localparam int NW = $clog2((VALUE_MAX + 2) > 10 ? (VALUE_MAX + 2) : 10);
	localparam int MW = NW + 4;

	localparam logic [NW-1:0] VMAX_N = NW'(VALUE_MAX);
	localparam logic [NW-1:0] VSAT_N = NW'(VALUE_MAX + 1);
	localparam logic [CW-1:0] VMAX_C = CW'(VALUE_MAX);
	localparam logic [CW-1:0] VEND_C = CW'(VALUE_MAX + 1);

	// Multiply by ten, add the digit, saturate one past the limit.
	function automatic logic [NW-1:0] accumulate(input logic [NW-1:0] v,
		input logic [7:0] c);
		logic [3:0]    dg;
		logic [MW-1:0] n;
		dg = 4'(c - CH_ZERO);
		n  = (MW'(v) << 3) + (MW'(v) << 1) + MW'(dg);
		return (n > MW'(VALUE_MAX + 1)) ? VSAT_N : NW'(n);
	endfunction

	// Control state
	rlss_state_t  state_q, state_d;
	parse_phase_t phase_q;
	logic         text_open_q, text_open_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] cursor_q, cursor_d;
	logic         ev_s1, ev_d;
	logic [AW-1:0] ev_addr_s1, ev_addr_d;
	logic         act_q, act_d;
	logic         cap_q, cap_d;
	logic         emit_q, emit_d;
	logic [AW-1:0] flo_q, flo_d;
	logic [AW-1:0] fhi_q, fhi_d;

	// Parse payload
	logic [NW-1:0] lower_q, upper_q;

	// Output register
	logic               out_valid_q;
	logic               kind_q, status_q, list_end_q;
	logic [FIELD_W-1:0] count_out_q, value_q;

	// Bitmap port
	logic          mem_we, mem_wd, rd_bit;
	logic [AW-1:0] mem_wa;

	logic in_acc, out_take;
	logic ld_status, ld_read, rd_end;
	logic [AW-1:0] rd_val;

	// Parser next values
	parse_phase_t  ph_e, ph_nx;
	logic [NW-1:0] lo_e, hi_e, lo_nx, hi_nx, fa, fb, mn, mx;
	logic          fin_add, fin_cap, dig;

	// Start of a fill: from the accept or after a clearing pass
	logic          do_start, st_add, st_cap, st_emit;
	logic [AW-1:0] st_lo, st_hi;
	logic          issue;

	assign out_take = out_valid_q && !out_stall;
	// Take a beat only when idle and the output slot is free by this edge.
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	rlss_bitmap #(
		.DEPTH(VALUE_MAX + 1),
		.AW   (AW)
	) u_bitmap (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_wa),
		.wdata(mem_wd),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rd_bit)
	);

	// Token parser: phase advance and the fill a delimiter triggers.
	always_comb begin
		ph_e    = text_open_q ? phase_q : PH_SEEK;
		lo_e    = text_open_q ? lower_q : '0;
		hi_e    = text_open_q ? upper_q : '0;
		dig     = is_digit(char_code);
		ph_nx   = ph_e;
		lo_nx   = lo_e;
		hi_nx   = hi_e;
		fin_add = 1'b0;
		fin_cap = 1'b1;
		fa      = lo_e;
		fb      = hi_e;
		if (is_delim(char_code)) begin
			ph_nx = PH_SEEK;
			case (ph_e)
				PH_LOW, PH_DONE_SINGLE: begin
					fin_add = 1'b1;
					fin_cap = 1'b0;
					fb      = lo_e;
				end
				PH_TRAIL_SEEK: begin
					fin_add = 1'b1;
					fb      = VMAX_N;
				end
				PH_UPPER, PH_DONE_RANGE: begin
					fin_add = 1'b1;
				end
				default: ;
			endcase
		end else begin
			case (ph_e)
				PH_SEEK: begin
					if (dig) begin
						lo_nx = NW'(char_code - CH_ZERO);
						ph_nx = PH_LOW;
					end else if (char_code == CH_DASH) begin
						lo_nx = '0;
						ph_nx = PH_LEAD_DASH;
					end
				end
				PH_LOW: begin
					if (dig) begin
						lo_nx = accumulate(lo_e, char_code);
					end else if (char_code == CH_DASH) begin
						ph_nx = PH_TRAIL_SEEK;
					end else begin
						ph_nx = PH_DONE_SINGLE;
					end
				end
				PH_LEAD_DASH, PH_TRAIL_SEEK: begin
					if (dig) begin
						hi_nx = NW'(char_code - CH_ZERO);
						ph_nx = PH_UPPER;
					end
				end
				PH_UPPER: begin
					if (dig) begin
						hi_nx = accumulate(hi_e, char_code);
					end else begin
						ph_nx = PH_DONE_RANGE;
					end
				end
				default: ;
			endcase
		end
		// Order the bounds, drop a range wholly past the limit, clamp the top.
		mn = (fa > fb) ? fb : fa;
		mx = (fa > fb) ? fa : fb;
		if (mn > VMAX_N) begin
			fin_add = 1'b0;
		end
		if (mx > VMAX_N) begin
			mx = VMAX_N;
		end
	end

	// Sequencer: clearing pass, range fill, ordered scan.
	always_comb begin
		state_d     = state_q;
		text_open_d = text_open_q;
		ptr_d       = ptr_q;
		count_d     = count_q;
		cursor_d    = cursor_q;
		ev_d        = 1'b0;
		ev_addr_d   = ptr_q[AW-1:0];
		act_d       = act_q;
		cap_d       = cap_q;
		emit_d      = emit_q;
		flo_d       = flo_q;
		fhi_d       = fhi_q;
		mem_we      = 1'b0;
		mem_wa      = ptr_q[AW-1:0];
		mem_wd      = 1'b0;
		ld_status   = 1'b0;
		ld_read     = 1'b0;
		rd_end      = 1'b0;
		rd_val      = ev_addr_s1;
		do_start    = 1'b0;
		st_add      = fin_add;
		st_cap      = fin_cap;
		st_emit     = 1'b0;
		st_lo       = AW'(mn);
		st_hi       = AW'(mx);
		issue       = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				ptr_d  = ptr_q + 1'b1;
				if (ptr_q == VMAX_C) begin
					do_start = 1'b1;
					st_add   = act_q;
					st_cap   = cap_q;
					st_lo    = flo_q;
					st_hi    = fhi_q;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (operation == OP_READ) begin
						state_d = ST_SCAN;
						ptr_d   = cursor_q;
					end else if (char_code == CH_NUL) begin
						text_open_d = 1'b0;
						cursor_d    = '0;
						do_start    = 1'b1;
						st_emit     = 1'b1;
					end else if (!text_open_q) begin
						// New text: sweep the map, then run any pending fill.
						text_open_d = 1'b1;
						count_d     = '0;
						cursor_d    = '0;
						ptr_d       = '0;
						state_d     = ST_CLEAR;
						act_d       = fin_add;
						cap_d       = fin_cap;
						flo_d       = AW'(mn);
						fhi_d       = AW'(mx);
						emit_d      = 1'b0;
					end else begin
						do_start = 1'b1;
					end
				end
			end
			ST_FILL: begin
				issue = ptr_q <= CW'(fhi_q);
				if (issue) begin
					ev_d  = 1'b1;
					ptr_d = ptr_q + 1'b1;
				end
				if (ev_s1 && !rd_bit && (!cap_q || count_q < VMAX_C)) begin
					mem_we  = 1'b1;
					mem_wa  = ev_addr_s1;
					mem_wd  = 1'b1;
					count_d = count_q + 1'b1;
				end
				if ((!issue && !ev_s1) || (cap_q && count_q >= VMAX_C)) begin
					state_d   = ST_IDLE;
					ev_d      = 1'b0;
					ld_status = emit_q;
				end
			end
			ST_SCAN: begin
				issue = ptr_q <= VMAX_C;
				if (ev_s1 && rd_bit) begin
					ld_read  = 1'b1;
					cursor_d = CW'(ev_addr_s1) + 1'b1;
					state_d  = ST_IDLE;
				end else if (!issue && !ev_s1) begin
					ld_read  = 1'b1;
					rd_end   = 1'b1;
					cursor_d = VEND_C;
					state_d  = ST_IDLE;
				end else if (issue) begin
					ev_d  = 1'b1;
					ptr_d = ptr_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (do_start) begin
			if (st_add) begin
				state_d = ST_FILL;
				ptr_d   = CW'(st_lo);
				fhi_d   = st_hi;
				cap_d   = st_cap;
				emit_d  = st_emit;
			end else begin
				state_d   = ST_IDLE;
				ld_status = st_emit;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_SEEK;
			text_open_q <= 1'b0;
			ptr_q       <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			ev_s1       <= 1'b0;
			act_q       <= 1'b0;
			cap_q       <= 1'b0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			text_open_q <= text_open_d;
			ptr_q       <= ptr_d;
			count_q     <= count_d;
			cursor_q    <= cursor_d;
			ev_s1       <= ev_d;
			act_q       <= act_d;
			cap_q       <= cap_d;
			emit_q      <= emit_d;
			if (in_acc && operation == OP_CHAR) begin
				phase_q <= ph_nx;
			end
			if (ld_status || ld_read) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		ev_addr_s1 <= ev_addr_d;
		flo_q      <= flo_d;
		fhi_q      <= fhi_d;
		if (in_acc && operation == OP_CHAR) begin
			lower_q <= lo_nx;
			upper_q <= hi_nx;
		end
		if (ld_status) begin
			kind_q      <= KIND_STATUS;
			status_q    <= (count_q == '0) ? STATUS_NONE : STATUS_OK;
			count_out_q <= FIELD_W'(count_q);
			value_q     <= '0;
			list_end_q  <= 1'b0;
		end else if (ld_read) begin
			kind_q      <= KIND_READ;
			status_q    <= STATUS_OK;
			count_out_q <= FIELD_W'(count_q);
			value_q     <= rd_end ? '0 : FIELD_W'(rd_val);
			list_end_q  <= rd_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status      = status_q;
	assign value_count = count_out_q;
	assign read_value  = value_q;
	assign list_end    = list_end_q;

endmodule
